// ===== rtl/kst_pkg.sv =====
// ----------------------------------------------------------------------------
// kst_pkg
// Shared types and codes for the keyed slot table.
// ----------------------------------------------------------------------------
package kst_pkg;

	localparam int TABLE_SLOTS_DEF = 64;

	localparam int CMD_W  = 3;
	localparam int KEY_W  = 27;
	localparam int SLOT_W = 6;
	localparam int STAT_W = 2;

	localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_LOOKUP   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_CHG_KEY  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CHG_DATE = 3'd4;
	localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd5;

	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
	} date_t;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [KEY_W-1:0] key;
		logic [KEY_W-1:0] new_key;
		logic [4:0]       birth_day;
		logic [3:0]       birth_month;
		logic [13:0]      birth_year;
	} cmd_item_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [SLOT_W-1:0] slot;
		logic [4:0]        found_day;
		logic [3:0]        found_month;
		logic [13:0]       found_year;
	} result_item_t;

	// travels down the cell chain, one cell per cycle
	typedef struct packed {
		logic              valid;
		logic              hit;
		logic [CMD_W-1:0]  command;
		logic [KEY_W-1:0]  key;
		logic [KEY_W-1:0]  new_key;
		date_t             date;
		logic [SLOT_W-1:0] slot;
		date_t             hit_date;
	} probe_t;

endpackage

// ===== rtl/kst_cell.sv =====
// ----------------------------------------------------------------------------
// kst_cell
// One table slot: empty flag, key and date, plus the probe register that
// hands the command on to the next slot.
// ----------------------------------------------------------------------------
module kst_cell #(
	parameter int CELL_INDEX = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  kst_pkg::probe_t probe_in,
	output kst_pkg::probe_t probe_out
);

	logic                      empty_q;
	logic [kst_pkg::KEY_W-1:0] key_q;
	kst_pkg::date_t            date_q;
	kst_pkg::probe_t           probe_q;
	kst_pkg::probe_t           probe_nxt;

	logic live;
	logic is_search;
	logic hit_ins;
	logic hit_srch;

	assign live      = probe_in.valid && !probe_in.hit;
	assign is_search = (probe_in.command == kst_pkg::CMD_DELETE)
		|| (probe_in.command == kst_pkg::CMD_LOOKUP)
		|| (probe_in.command == kst_pkg::CMD_CHG_KEY)
		|| (probe_in.command == kst_pkg::CMD_CHG_DATE);
	assign hit_ins   = live && (probe_in.command == kst_pkg::CMD_INSERT) && empty_q;
	assign hit_srch  = live && is_search && !empty_q && (key_q == probe_in.key);

	always_comb begin
		probe_nxt = probe_in;
		if (hit_ins || hit_srch) begin
			probe_nxt.hit  = 1'b1;
			probe_nxt.slot = kst_pkg::SLOT_W'(CELL_INDEX);
			if (hit_ins || (probe_in.command == kst_pkg::CMD_CHG_DATE)) begin
				probe_nxt.hit_date = probe_in.date;
			end else begin
				probe_nxt.hit_date = date_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_q <= 1'b1;
		end else if (probe_in.valid && (probe_in.command == kst_pkg::CMD_CLEAR)) begin
			empty_q <= 1'b1;
		end else if (hit_ins) begin
			empty_q <= 1'b0;
		end else if (hit_srch && (probe_in.command == kst_pkg::CMD_DELETE)) begin
			empty_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (hit_ins) begin
			key_q  <= probe_in.key;
			date_q <= probe_in.date;
		end else if (hit_srch && (probe_in.command == kst_pkg::CMD_CHG_KEY)) begin
			key_q <= probe_in.new_key;
		end else if (hit_srch && (probe_in.command == kst_pkg::CMD_CHG_DATE)) begin
			date_q <= probe_in.date;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_q <= '0;
		end else begin
			probe_q <= probe_nxt;
		end
	end

	assign probe_out = probe_q;

endmodule

// ===== rtl/keyed_slot_table_unit.sv =====
// ----------------------------------------------------------------------------
// keyed_slot_table_unit
// From accepted start to the done strobe the command walks the slot chain
// one slot per cycle, and the result is registered after the last slot.
// One item at a time: busy is high from the accepted start and drops in the
// strobe cycle so the next start can be taken there. Receiver cannot stall.
// Reset: every slot empty, chain idle; keys and dates hold no reset value.
// ----------------------------------------------------------------------------
module keyed_slot_table_unit #(
	parameter int TABLE_SLOTS = kst_pkg::TABLE_SLOTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  kst_pkg::cmd_item_t    request,
	output logic                  done,
	output kst_pkg::result_item_t response
);

	kst_pkg::probe_t link [0:TABLE_SLOTS];
	kst_pkg::probe_t head;
	kst_pkg::probe_t last;

	logic                  busy_q;
	logic                  done_q;
	kst_pkg::result_item_t response_q;
	logic                  accept;

	assign accept = start && !busy_q;

	always_comb begin
		head.valid      = accept;
		head.hit        = 1'b0;
		head.command    = request.command;
		head.key        = request.key;
		head.new_key    = request.new_key;
		head.date.day   = request.birth_day;
		head.date.month = request.birth_month;
		head.date.year  = request.birth_year;
		head.slot       = '0;
		head.hit_date   = '0;
	end

	assign link[0] = head;

	genvar gi;
	generate
		for (gi = 0; gi < TABLE_SLOTS; gi++) begin : g_cell
			kst_cell #(
				.CELL_INDEX(gi)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.probe_in (link[gi]),
				.probe_out(link[gi+1])
			);
		end
	endgenerate

	assign last = link[TABLE_SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= last.valid;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (last.valid) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (last.valid) begin
			if (last.hit) begin
				response_q.status      <= kst_pkg::STAT_OK;
				response_q.slot        <= last.slot;
				response_q.found_day   <= last.hit_date.day;
				response_q.found_month <= last.hit_date.month;
				response_q.found_year  <= last.hit_date.year;
			end else begin
				case (last.command)
					kst_pkg::CMD_CLEAR:  response_q.status <= kst_pkg::STAT_OK;
					kst_pkg::CMD_INSERT: response_q.status <= kst_pkg::STAT_FULL;
					default:             response_q.status <= kst_pkg::STAT_NOTFOUND;
				endcase
				response_q.slot        <= '0;
				response_q.found_day   <= '0;
				response_q.found_month <= '0;
				response_q.found_year  <= '0;
			end
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign response = response_q;

endmodule
